### src/lkv_pkg.sv
// ----------------------------------------------------------------------------
// lkv_pkg
// Shared constants and controller/datapath command and status types for the
// LRU key-value cache.
// ----------------------------------------------------------------------------
package lkv_pkg;

   localparam int DEFAULT_MAX_ENTRIES = 16;
   localparam int KEY_W               = 32;
   localparam int VAL_W               = 32;
   localparam int CAP_W               = 5;
   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   // request kinds
   localparam logic OP_GET = 1'b0;
   localparam logic OP_PUT = 1'b1;

   // controller to datapath
   typedef struct packed {
      logic start;    // latch request, restart scan
      logic scan;     // issue next key read
      logic apply;    // update ranks, valid bits and memories
      logic finish;   // load response register
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic scan_last;  // key read for the highest slot is being issued
   } status_type;

endpackage

### src/lkv_if.sv
// ----------------------------------------------------------------------------
// lkv channel interfaces
// Request, response and register-write channels, each with valid and ready.
// ----------------------------------------------------------------------------
interface lkv_req_if;
   logic               valid;
   logic               ready;
   logic               op;
   logic signed [31:0] lookup_key;
   logic signed [31:0] write_value;

   modport source (output valid, output op, output lookup_key, output write_value,
                   input ready);
   modport sink   (input valid, input op, input lookup_key, input write_value,
                   output ready);
endinterface

interface lkv_rsp_if;
   logic               valid;
   logic               ready;
   logic               hit;
   logic signed [31:0] read_value;

   modport source (output valid, output hit, output read_value, input ready);
   modport sink   (input valid, input hit, input read_value, output ready);
endinterface

interface lkv_csr_if;
   logic       valid;
   logic       ready;
   logic [4:0] active_capacity;

   modport source (output valid, output active_capacity, input ready);
   modport sink   (input valid, input active_capacity, output ready);
endinterface

### src/lkv_ram.sv
// ----------------------------------------------------------------------------
// lkv_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lkv_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### src/lkv_ctrl.sv
// ----------------------------------------------------------------------------
// lkv_ctrl
// Sequencer: accept, scan all slots, apply the update, hand over the result.
// ----------------------------------------------------------------------------
module lkv_ctrl
   import lkv_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output cmd_type    cmd,
   input  status_type status
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SCAN   = 3'd1;
   localparam logic [2:0] ST_TAIL   = 3'd2;
   localparam logic [2:0] ST_APPLY  = 3'd3;
   localparam logic [2:0] ST_RESULT = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       rsp_free;

   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in  = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (status.scan_last) begin
               state_in = ST_TAIL;
            end
         end
         ST_TAIL: begin
            state_in = ST_APPLY;
         end
         ST_APPLY: begin
            cmd.apply = 1'b1;
            state_in  = ST_RESULT;
         end
         ST_RESULT: begin
            if (rsp_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

### src/lkv_dpath.sv
// ----------------------------------------------------------------------------
// lkv_dpath
// Key and value memories, valid bits, recency ranks, scan trackers and the
// response register.
// ----------------------------------------------------------------------------
module lkv_dpath
   import lkv_pkg::*;
#(
   parameter int MAX_ENTRIES = DEFAULT_MAX_ENTRIES
) (
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   output status_type         status,
   input  logic               req_op,
   input  logic [KEY_W-1:0]   req_key,
   input  logic [VAL_W-1:0]   req_value,
   input  logic               csr_write,
   input  logic [CAP_W-1:0]   csr_data,
   output logic               rsp_hit,
   output logic [VAL_W-1:0]   rsp_value
);

   localparam int IW = $clog2(MAX_ENTRIES);
   localparam int CW = $clog2(MAX_ENTRIES + 1);
   localparam int EW = (CW > CAP_W) ? CW : CAP_W;

   // request
   logic             op_ff;
   logic [KEY_W-1:0] key_ff;
   logic [VAL_W-1:0] val_ff;

   // configuration
   logic [CAP_W-1:0] cap_ff, cap_in;

   // entry state
   logic [MAX_ENTRIES-1:0] valid_ff, valid_in;
   logic [IW-1:0]          rank_ff [MAX_ENTRIES];
   logic [IW-1:0]          rank_in [MAX_ENTRIES];
   logic [CW-1:0]          count_ff, count_in;

   // scan
   logic [IW-1:0] addr_ff, addr_in;
   logic          cmp_valid_ff, cmp_valid_in;
   logic [IW-1:0] cmp_idx_ff, cmp_idx_in;

   logic          match_found_ff, match_found_in;
   logic [IW-1:0] match_slot_ff, match_slot_in;
   logic [IW-1:0] match_rank_ff, match_rank_in;
   logic          free_found_ff, free_found_in;
   logic [IW-1:0] free_slot_ff, free_slot_in;
   logic          old_found_ff, old_found_in;
   logic [IW-1:0] old_slot_ff, old_slot_in;

   // response
   logic             hit_ff, hit_in;
   logic [VAL_W-1:0] rsp_value_ff, rsp_value_in;
   logic             get_hit_ff, get_hit_in;

   // memories
   logic [KEY_W-1:0] key_rd;
   logic [VAL_W-1:0] val_rd;
   logic             key_wr_en, val_wr_en, val_rd_en;
   logic [IW-1:0]    wr_slot;

   // apply decisions
   logic [EW-1:0] cap_ext, eff_cap;
   logic          evict, insert;
   logic [IW-1:0] ins_slot;

   lkv_ram #(.WIDTH(KEY_W), .DEPTH(MAX_ENTRIES)) u_key_ram (
      .clock   (clock),
      .wr_en   (key_wr_en),
      .wr_addr (wr_slot),
      .wr_data (key_ff),
      .rd_en   (cmd.scan),
      .rd_addr (addr_ff),
      .rd_data (key_rd)
   );

   lkv_ram #(.WIDTH(VAL_W), .DEPTH(MAX_ENTRIES)) u_val_ram (
      .clock   (clock),
      .wr_en   (val_wr_en),
      .wr_addr (wr_slot),
      .wr_data (val_ff),
      .rd_en   (val_rd_en),
      .rd_addr (match_slot_ff),
      .rd_data (val_rd)
   );

   assign status.scan_last = (addr_ff == IW'(MAX_ENTRIES - 1));

   // capacity clamp: zero acts as one, above the slot count acts as the slot count
   assign cap_ext = EW'(cap_ff);
   always_comb begin
      if (cap_ff == '0) begin
         eff_cap = EW'(1);
      end else if (cap_ext > EW'(MAX_ENTRIES)) begin
         eff_cap = EW'(MAX_ENTRIES);
      end else begin
         eff_cap = cap_ext;
      end
   end

   assign evict  = (op_ff == OP_PUT) && !match_found_ff && (EW'(count_ff) >= eff_cap)
                   && old_found_ff;
   assign insert = (op_ff == OP_PUT) && !match_found_ff && (evict || free_found_ff);

   // lowest free slot, counting the one the eviction frees
   always_comb begin
      if (evict && (!free_found_ff || (old_slot_ff < free_slot_ff))) begin
         ins_slot = old_slot_ff;
      end else begin
         ins_slot = free_slot_ff;
      end
   end

   assign wr_slot   = match_found_ff ? match_slot_ff : ins_slot;
   assign key_wr_en = cmd.apply && insert;
   assign val_wr_en = cmd.apply && (op_ff == OP_PUT) && (match_found_ff || insert);
   assign val_rd_en = cmd.apply && (op_ff == OP_GET) && match_found_ff;

   assign cap_in = csr_write ? csr_data : cap_ff;

   // scan address and compare pipeline
   always_comb begin
      addr_in      = addr_ff;
      cmp_valid_in = cmd.scan;
      cmp_idx_in   = addr_ff;
      if (cmd.start) begin
         addr_in = '0;
      end else if (cmd.scan) begin
         addr_in = addr_ff + IW'(1);
      end
   end

   // trackers: matching key, first free slot, least recent slot
   always_comb begin
      match_found_in = match_found_ff;
      match_slot_in  = match_slot_ff;
      match_rank_in  = match_rank_ff;
      free_found_in  = free_found_ff;
      free_slot_in   = free_slot_ff;
      old_found_in   = old_found_ff;
      old_slot_in    = old_slot_ff;
      if (cmd.start) begin
         match_found_in = 1'b0;
         free_found_in  = 1'b0;
         old_found_in   = 1'b0;
      end else if (cmp_valid_ff) begin
         if (valid_ff[cmp_idx_ff] && (key_rd == key_ff)) begin
            match_found_in = 1'b1;
            match_slot_in  = cmp_idx_ff;
            match_rank_in  = rank_ff[cmp_idx_ff];
         end
         if (!valid_ff[cmp_idx_ff] && !free_found_ff) begin
            free_found_in = 1'b1;
            free_slot_in  = cmp_idx_ff;
         end
         if (valid_ff[cmp_idx_ff] && (CW'(rank_ff[cmp_idx_ff]) == (count_ff - CW'(1)))) begin
            old_found_in = 1'b1;
            old_slot_in  = cmp_idx_ff;
         end
      end
   end

   // recency ranks, valid bits and fill count
   always_comb begin
      valid_in = valid_ff;
      count_in = count_ff;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         rank_in[i] = rank_ff[i];
      end
      if (cmd.apply) begin
         if (match_found_ff) begin
            // hit: younger entries age by one, the hit entry becomes most recent
            for (int i = 0; i < MAX_ENTRIES; i++) begin
               if (IW'(i) == match_slot_ff) begin
                  rank_in[i] = '0;
               end else if (valid_ff[i] && (rank_ff[i] < match_rank_ff)) begin
                  rank_in[i] = rank_ff[i] + IW'(1);
               end
            end
         end else if (insert) begin
            for (int i = 0; i < MAX_ENTRIES; i++) begin
               if (evict && (IW'(i) == old_slot_ff)) begin
                  valid_in[i] = 1'b0;
                  rank_in[i]  = '0;
               end else if (valid_ff[i]) begin
                  rank_in[i] = rank_ff[i] + IW'(1);
               end
               if (IW'(i) == ins_slot) begin
                  valid_in[i] = 1'b1;
                  rank_in[i]  = '0;
               end
            end
            count_in = count_ff - CW'(evict) + CW'(1);
         end
      end
   end

   // response
   always_comb begin
      hit_in       = hit_ff;
      get_hit_in   = get_hit_ff;
      rsp_value_in = rsp_value_ff;
      if (cmd.apply) begin
         get_hit_in = (op_ff == OP_GET) && match_found_ff;
      end
      if (cmd.finish) begin
         hit_in       = match_found_ff;
         rsp_value_in = get_hit_ff ? val_rd : '0;
      end
   end

   assign rsp_hit   = hit_ff;
   assign rsp_value = rsp_value_ff;

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         op_ff  <= req_op;
         key_ff <= req_key;
         val_ff <= req_value;
      end
      addr_ff       <= addr_in;
      cmp_idx_ff    <= cmp_idx_in;
      match_slot_ff <= match_slot_in;
      match_rank_ff <= match_rank_in;
      free_slot_ff  <= free_slot_in;
      old_slot_ff   <= old_slot_in;
      hit_ff        <= hit_in;
      get_hit_ff    <= get_hit_in;
      rsp_value_ff  <= rsp_value_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff         <= CAP_RESET;
         valid_ff       <= '0;
         count_ff       <= '0;
         cmp_valid_ff   <= 1'b0;
         match_found_ff <= 1'b0;
         free_found_ff  <= 1'b0;
         old_found_ff   <= 1'b0;
         for (int i = 0; i < MAX_ENTRIES; i++) begin
            rank_ff[i] <= '0;
         end
      end else begin
         cap_ff         <= cap_in;
         valid_ff       <= valid_in;
         count_ff       <= count_in;
         cmp_valid_ff   <= cmp_valid_in;
         match_found_ff <= match_found_in;
         free_found_ff  <= free_found_in;
         old_found_ff   <= old_found_in;
         for (int i = 0; i < MAX_ENTRIES; i++) begin
            rank_ff[i] <= rank_in[i];
         end
      end
   end

endmodule

### src/lru_key_value_cache.sv
// ----------------------------------------------------------------------------
// lru_key_value_cache
// Key-value store of MAX_ENTRIES pairs with least-recently-used replacement.
// ----------------------------------------------------------------------------
// Usage:
//   req_if  : one transfer per request - op (get/put), lookup_key, write_value.
//   rsp_if  : one transfer per request - hit, read_value (value on a get hit,
//             zero otherwise).
//   csr_if  : writes active_capacity; always ready. Write only while idle.
// Sequence:
//   After a request transfer the block reads every key slot from the key
//   memory, one slot per cycle, then finishes the last compare, applies the
//   update and loads the response register. The next request is taken only
//   once the response register has been loaded and the block is idle. The
//   single read port of the key memory sets the slot-by-slot scan.
// Reset:
//   Clears every valid bit, recency rank and the fill count, and sets the
//   capacity to 16. Key and value memories are not cleared.
// Stall:
//   A response not yet taken holds in the output register; the next request
//   is still accepted and scanned, and its result waits for the register.
// ----------------------------------------------------------------------------
module lru_key_value_cache
   import lkv_pkg::*;
#(
   parameter int MAX_ENTRIES = DEFAULT_MAX_ENTRIES
) (
   input  logic     clock,
   input  logic     reset,
   lkv_req_if.sink  req_if,
   lkv_rsp_if.source rsp_if,
   lkv_csr_if.sink  csr_if
);

   cmd_type          cmd;
   status_type       status;
   logic [VAL_W-1:0] rsp_value;

   // configuration writes never stall
   assign csr_if.ready = 1'b1;

   // sequencer: owns the request and response handshakes and the response valid flag
   lkv_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .cmd       (cmd),
      .status    (status)
   );

   // datapath: memories, recency state and the response payload
   lkv_dpath #(.MAX_ENTRIES(MAX_ENTRIES)) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_op    (req_if.op),
      .req_key   (req_if.lookup_key),
      .req_value (req_if.write_value),
      .csr_write (csr_if.valid),
      .csr_data  (csr_if.active_capacity),
      .rsp_hit   (rsp_if.hit),
      .rsp_value (rsp_value)
   );

   assign rsp_if.read_value = rsp_value;

endmodule
